// ===== rtl/jbd_pkg.sv =====
// Shared constants, types and result record for the joystick boxcar direction block.
package jbd_pkg;

	localparam int WINDOW_DEPTH = 32;	// power of two: the mean is a shift
	localparam int SAMPLE_BITS = 12;
	localparam int CFG_BITS = 12;
	localparam int OFFSET_BITS = 13;
	localparam int MAG_BITS = 6;
	localparam int MAG_SHIFT = 6;
	localparam int DIR_BITS = 2;
	localparam int CODE_BITS = 8;

	localparam int SLOT_BITS = $clog2(WINDOW_DEPTH);
	localparam int SUM_BITS = SAMPLE_BITS + SLOT_BITS;
	localparam int POS_BITS = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 1;

	localparam int IN_BITS = 2 * SAMPLE_BITS;
	localparam int IN_BYTES_BITS = ((IN_BITS + 7) / 8) * 8;
	localparam int RES_BITS = 2 * OFFSET_BITS + DIR_BITS + MAG_BITS + CODE_BITS;
	localparam int OUT_BYTES_BITS = ((RES_BITS + 7) / 8) * 8;

	localparam logic [CFG_BITS-1:0] CENTER_RESET = CFG_BITS'(2048);

	typedef enum logic [DIR_BITS-1:0] {
		DIR_LEFT  = 2'b00,
		DIR_RIGHT = 2'b01,
		DIR_DOWN  = 2'b10,
		DIR_UP    = 2'b11
	} dir_t;

	typedef struct packed {
		logic [CODE_BITS-1:0]   packed_code;
		logic [MAG_BITS-1:0]    magnitude_code;
		dir_t                   direction;
		logic [OFFSET_BITS-1:0] y_offset;
		logic [OFFSET_BITS-1:0] x_offset;
	} res_t;

endpackage

// ===== rtl/jbd_window.sv =====
// One axis: 32-deep boxcar ring with its running sum.
module jbd_window import jbd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [SLOT_BITS-1:0] slot,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [SUM_BITS-1:0]  sum
);

	logic [SAMPLE_BITS-1:0] win_q [WINDOW_DEPTH];
	logic [SUM_BITS-1:0]    sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				win_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (en) begin
			win_q[slot] <= sample;
			sum_q <= sum_q - SUM_BITS'(win_q[slot]) + SUM_BITS'(sample);
		end
	end

	assign sum = sum_q;

endmodule

// ===== rtl/jbd_classify.sv =====
// Mean, center offset, dominant axis and packed direction code.
module jbd_classify import jbd_pkg::*; (
	input  logic [SUM_BITS-1:0] x_sum,
	input  logic [SUM_BITS-1:0] y_sum,
	input  logic [CFG_BITS-1:0] center,
	output res_t                res
);

	logic signed [POS_BITS-1:0] x_pos, y_pos;
	logic [POS_BITS-1:0]        x_abs, y_abs, mag_abs;
	logic                       x_dom;
	dir_t                       dir;
	logic [MAG_BITS-1:0]        mag;

	always_comb begin
		x_pos = $signed(POS_BITS'(x_sum[SUM_BITS-1:SLOT_BITS])) - $signed(POS_BITS'(center));
		y_pos = $signed(POS_BITS'(y_sum[SUM_BITS-1:SLOT_BITS])) - $signed(POS_BITS'(center));
		x_abs = x_pos[POS_BITS-1] ? POS_BITS'(-x_pos) : POS_BITS'(x_pos);
		y_abs = y_pos[POS_BITS-1] ? POS_BITS'(-y_pos) : POS_BITS'(y_pos);
		// tie goes to y; zero counts as left or down
		x_dom = x_abs > y_abs;
		if (x_dom) begin
			mag_abs = x_abs;
			dir = (!x_pos[POS_BITS-1] && (|x_pos)) ? DIR_RIGHT : DIR_LEFT;
		end else begin
			mag_abs = y_abs;
			dir = (!y_pos[POS_BITS-1] && (|y_pos)) ? DIR_UP : DIR_DOWN;
		end
		mag = MAG_BITS'(mag_abs >> MAG_SHIFT);

		res.x_offset = OFFSET_BITS'(x_pos);
		res.y_offset = OFFSET_BITS'(y_pos);
		res.direction = dir;
		res.magnitude_code = mag;
		res.packed_code = {dir, mag};
	end

endmodule

// ===== rtl/joystick_boxcar_direction_top.sv =====
// Top level: stream ports, window update stage and result register.
//
// Usage: one x/y sample pair per request on the s_ group (s_tdata: x_sample [11:0],
// y_sample [23:12]). Each request produces exactly one result on the m_ group
// (m_tdata: x_offset, y_offset, direction, magnitude_code, packed_code, low bit up).
// Stage 1 updates both 32-deep rings and running sums; stage 2 takes the mean,
// subtracts center_offset, picks the dominant axis and loads the result register.
// Two registers lie between a request and m_tvalid: the rings and sums, then the result register.
// Throughput: one request per cycle while results drain; the ring read-modify-write of one slot and
// the 17-bit sum update are the per-cycle path.
// Stalls: a result waits in the result register while m_tready is low; stage 1
// still takes one more request, then s_tready drops until the result drains.
// Reset (arst_n low): rings, sums and slot clear to zero, center_offset goes to
// 2048, both stages empty. The first 31 results average in the cleared entries.
// cfg_we writes center_offset from cfg_wdata; write it only while idle.
module joystick_boxcar_direction_top import jbd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_BITS-1:0]       cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_BYTES_BITS-1:0]  s_tdata,	// x_sample, y_sample
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_BYTES_BITS-1:0] m_tdata	// x_offset, y_offset, direction, magnitude_code, packed_code
);

	logic [CFG_BITS-1:0]  center_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic                 valid_s1;
	logic                 valid_s2;
	res_t                 res_s2;
	res_t                 res;
	logic [SUM_BITS-1:0]  x_sum, y_sum;
	logic                 take, adv_s1, load_s2;

	assign load_s2 = !valid_s2 || m_tready;
	assign adv_s1 = valid_s1 && load_s2;
	assign s_tready = !valid_s1 || load_s2;
	assign take = s_tvalid && s_tready;

	jbd_window u_x_win (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (take),
		.slot   (slot_q),
		.sample (s_tdata[SAMPLE_BITS-1:0]),
		.sum    (x_sum)
	);

	jbd_window u_y_win (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (take),
		.slot   (slot_q),
		.sample (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.sum    (y_sum)
	);

	jbd_classify u_classify (
		.x_sum  (x_sum),
		.y_sum  (y_sum),
		.center (center_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RESET;
			slot_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				center_q <= cfg_wdata;
			end
			if (take) begin
				slot_q <= (slot_q == SLOT_BITS'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
			if (s_tready) begin
				valid_s1 <= take;
			end
			if (load_s2) begin
				valid_s2 <= adv_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = OUT_BYTES_BITS'(res_s2);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with empty result register");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (!valid_s1 || adv_s1))
		else $error("request taken over an unconsumed stage-1 item");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("stage-1 item did not reach the empty result register");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.packed_code == {res_s2.direction, res_s2.magnitude_code}))
		else $error("packed code disagrees with direction and magnitude");

endmodule

// ===== verif/tb_joystick_boxcar_direction_top.sv =====
// Self-checking testbench for joystick_boxcar_direction_top: stream stimulus and per-result checks.
module tb_joystick_boxcar_direction_top import jbd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_REPORTS = 10;
	localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_BITS-1:0]       cfg_wdata = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [IN_BYTES_BITS-1:0]  s_tdata = '0;	// x_sample, y_sample
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_BYTES_BITS-1:0] m_tdata;	// x_offset, y_offset, direction, magnitude_code, packed_code

	joystick_boxcar_direction_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// predictor state
	logic [SAMPLE_BITS-1:0] x_ring [WINDOW_DEPTH];
	logic [SAMPLE_BITS-1:0] y_ring [WINDOW_DEPTH];
	logic [SUM_BITS-1:0]    x_sum;
	logic [SUM_BITS-1:0]    y_sum;
	logic [SLOT_BITS-1:0]   ring_slot;
	logic [CFG_BITS-1:0]    center;

	res_t pending_directions[$];
	int   mismatches = 0;
	int   stall_left = 0;
	int   idle_cycles = 0;
	bit   steady_flow = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] sample_near(int target);
		int v;
		v = target + $urandom_range(0, 128) - 64;
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return SAMPLE_BITS'(v);
	endfunction

	function automatic res_t predict_direction(logic [SAMPLE_BITS-1:0] xs,
			logic [SAMPLE_BITS-1:0] ys);
		res_t r;
		int xpos, ypos, ax, ay, mag;
		dir_t dir;
		logic [MAG_BITS-1:0] code;
		x_sum = x_sum - x_ring[ring_slot] + xs;
		y_sum = y_sum - y_ring[ring_slot] + ys;
		x_ring[ring_slot] = xs;
		y_ring[ring_slot] = ys;
		ring_slot = ring_slot + 1'b1;
		xpos = int'(x_sum >> SLOT_BITS) - int'(center);
		ypos = int'(y_sum >> SLOT_BITS) - int'(center);
		ax = (xpos < 0) ? -xpos : xpos;
		ay = (ypos < 0) ? -ypos : ypos;
		if (ax > ay) begin
			mag = ax;
			dir = (xpos > 0) ? DIR_RIGHT : DIR_LEFT;
		end else begin
			mag = ay;
			dir = (ypos > 0) ? DIR_UP : DIR_DOWN;
		end
		code = MAG_BITS'(mag >> MAG_SHIFT);
		r.x_offset = OFFSET_BITS'(xpos);
		r.y_offset = OFFSET_BITS'(ypos);
		r.direction = dir;
		r.magnitude_code = code;
		r.packed_code = {dir, code};
		return r;
	endfunction

	task automatic note_mismatch(string field, longint want, longint got);
		if (mismatches < MAX_REPORTS)
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
		mismatches++;
	endtask

	task automatic check_result(res_t got);
		res_t want;
		if (pending_directions.size() == 0) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: unexpected result 0x%0h", $realtime, got);
			mismatches++;
		end else begin
			want = pending_directions.pop_front();
			if (got.x_offset !== want.x_offset)
				note_mismatch("x_offset", want.x_offset, got.x_offset);
			if (got.y_offset !== want.y_offset)
				note_mismatch("y_offset", want.y_offset, got.y_offset);
			if (got.direction !== want.direction)
				note_mismatch("direction", want.direction, got.direction);
			if (got.magnitude_code !== want.magnitude_code)
				note_mismatch("magnitude_code", want.magnitude_code, got.magnitude_code);
			if (got.packed_code !== want.packed_code)
				note_mismatch("packed_code", want.packed_code, got.packed_code);
		end
	endtask

	// result side: checker plus random backpressure
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			check_result(res_t'(m_tdata[RES_BITS-1:0]));
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (steady_flow || $urandom_range(0, 99) < 70) begin
			m_tready <= 1'b1;
		end else begin
			stall_left <= pick_gap();
			m_tready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_joystick_boxcar_direction_top failed");
				$finish;
			end
		end
	end

	task automatic send_pair(logic [SAMPLE_BITS-1:0] xs, logic [SAMPLE_BITS-1:0] ys);
		int gap;
		gap = steady_flow ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ys, xs};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_directions.push_back(predict_direction(xs, ys));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_directions.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_center(logic [CFG_BITS-1:0] value);
		wait_drained();
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		center = value;
	endtask

	task automatic send_mode(int mode, int count);
		int tx, ty;
		tx = $urandom_range(0, SAMPLE_MAX);
		ty = $urandom_range(0, SAMPLE_MAX);
		repeat (count) begin
			case (mode)
				0: send_pair(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
				1: send_pair(sample_near(tx), sample_near(ty));
				default: send_pair($urandom_range(0, 1) ? FULL_SCALE : '0,
						$urandom_range(0, 1) ? FULL_SCALE : '0);
			endcase
		end
	endtask

	task automatic test_directed();
		send_pair('0, '0);
		send_pair(FULL_SCALE, FULL_SCALE);
		send_pair(FULL_SCALE, '0);
		send_pair('0, FULL_SCALE);
		send_pair(12'h800, 12'h800);
		send_pair(12'hAAA, 12'h555);
		send_pair(12'h555, 12'hAAA);
		send_pair(12'h001, 12'hFFE);
		send_pair(12'hFFE, 12'h001);
		send_pair(12'h7FF, 12'h801);
		repeat (6) send_pair(FULL_SCALE, '0);
		repeat (6) send_pair('0, FULL_SCALE);
	endtask

	// tie on equal windows, then exact zero position after the window refills
	task automatic test_tie_and_zero();
		logic [SAMPLE_BITS-1:0] level;
		level = SAMPLE_BITS'($urandom);
		write_center(level);
		repeat (WINDOW_DEPTH + 4) send_pair(level, level);
	endtask

	task automatic test_center_settings();
		write_center('0);
		send_mode(1, 30);
		write_center('1);
		send_mode(1, 30);
		write_center(CENTER_RESET);
		send_mode(2, 30);
		repeat (2) begin
			write_center(CFG_BITS'($urandom));
			send_mode(1, 30);
		end
	endtask

	task automatic test_random();
		for (int chunk = 0; chunk < 20; chunk++) begin
			steady_flow = ($urandom_range(0, 4) == 0);
			send_mode($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 9) < 7 ? 0 : 2, 40);
			if (chunk == 9)
				write_center(CFG_BITS'($urandom));
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_drain_pause();
		repeat (3) begin
			send_mode(0, 10);
			wait_drained();
		end
	endtask

	initial begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			x_ring[i] = '0;
			y_ring[i] = '0;
		end
		x_sum = '0;
		y_sum = '0;
		ring_slot = '0;
		center = CENTER_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_tie_and_zero();
		test_center_settings();
		test_random();
		test_drain_pause();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_joystick_boxcar_direction_top passed");
		else
			$display("tb_joystick_boxcar_direction_top failed");
		$finish;
	end

endmodule
